/* src/urb_pkg.sv */
// Shared types and constants for the UART ring buffer pair.
// Used by the interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package urb_pkg;

    localparam int DEPTH = 32;
    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        F_HOST_RD = 2'd0,
        F_HOST_WR = 2'd1,
        F_LINE_RX = 2'd2,
        F_LINE_TX = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_OVERRUN = 3'd3,
        ST_IGNORED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic start;   // input transfer: decide, move pointers, write buffer
        logic load;    // buffer read data is valid: capture popped byte
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic pop;     // the offered event pops a buffer
    } t_sts;

endpackage

`default_nettype wire

/* src/urb_if.sv */
// Handshake channels of the UART ring buffer pair: event in, result out.
// Depends on urb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface urb_in_if import urb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] byte_in;

    modport source (output valid, output func, output byte_in, input ready);
    modport sink   (input valid, input func, input byte_in, output ready);
endinterface

interface urb_out_if import urb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   read_byte;
    logic [BYTE_W-1:0]   line_byte;
    logic                line_send;
    logic [STATUS_W-1:0] status;
    logic                rx_irq_on;
    logic                tx_irq_on;

    modport source (output valid, output read_byte, output line_byte, output line_send,
                    output status, output rx_irq_on, output tx_irq_on, input ready);
    modport sink   (input valid, input read_byte, input line_byte, input line_send,
                    input status, input rx_irq_on, input tx_irq_on, output ready);
endinterface

`default_nettype wire

/* src/urb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module urb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* src/urb_datapath.sv */
// Datapath: ring pointers, interrupt enables, the two byte buffers and result registers.
// Depends on urb_pkg and urb_ram.
`timescale 1ns / 1ps
`default_nettype none

module urb_datapath import urb_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output      t_sts                o_sts,
    input  wire logic [FUNC_W-1:0]   i_func,
    input  wire logic [BYTE_W-1:0]   i_byte_in,
    output      logic [BYTE_W-1:0]   o_read_byte,
    output      logic [BYTE_W-1:0]   o_line_byte,
    output      logic                o_line_send,
    output      logic [STATUS_W-1:0] o_status,
    output      logic                o_rx_irq_on,
    output      logic                o_tx_irq_on
);

    logic [PTR_W-1:0] r_rx_head, r_rx_tail, r_tx_head, r_tx_tail;
    logic             r_rx_en, r_tx_en;
    logic             r_rx_pop, r_tx_pop;
    logic [BYTE_W-1:0] r_read_byte, r_line_byte;
    logic             r_line_send;
    t_status          r_status;

    logic [PTR_W-1:0] rx_head_nx, rx_tail_nx, tx_head_nx, tx_tail_nx;
    logic             rx_push, rx_pop, tx_push, tx_pop;
    logic             n_rx_en, n_tx_en;
    t_status          n_status;
    logic [BYTE_W-1:0] rx_rdata, tx_rdata;

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign rx_head_nx = wrap_next(r_rx_head);
    assign rx_tail_nx = wrap_next(r_rx_tail);
    assign tx_head_nx = wrap_next(r_tx_head);
    assign tx_tail_nx = wrap_next(r_tx_tail);

    always_comb begin
        rx_push  = 1'b0;
        rx_pop   = 1'b0;
        tx_push  = 1'b0;
        tx_pop   = 1'b0;
        n_rx_en  = r_rx_en;
        n_tx_en  = r_tx_en;
        n_status = ST_OK;
        unique case (t_func'(i_func))
            F_HOST_RD: begin
                if (r_rx_head == r_rx_tail) begin
                    n_status = ST_EMPTY;
                end else begin
                    rx_pop  = 1'b1;
                    n_rx_en = 1'b1;
                end
            end
            F_HOST_WR: begin
                if (tx_head_nx == r_tx_tail) begin
                    n_status = ST_FULL;
                end else begin
                    tx_push = 1'b1;
                    n_tx_en = 1'b1;
                end
            end
            F_LINE_RX: begin
                if (!r_rx_en || rx_head_nx == r_rx_tail) begin
                    n_rx_en  = 1'b0;
                    n_status = ST_OVERRUN;
                end else begin
                    rx_push = 1'b1;
                end
            end
            F_LINE_TX: begin
                if (!r_tx_en) begin
                    n_status = ST_IGNORED;
                end else if (r_tx_head != r_tx_tail) begin
                    tx_pop = 1'b1;
                end else begin
                    n_tx_en  = 1'b0;
                    n_status = ST_EMPTY;
                end
            end
            default: n_status = ST_IGNORED;
        endcase
    end

    assign o_sts.pop = rx_pop | tx_pop;

    // Read address is always the slot after tail; on a pop the data lands next cycle.
    urb_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.start & rx_push),
        .i_waddr (rx_head_nx),
        .i_wdata (i_byte_in),
        .i_raddr (rx_tail_nx),
        .o_rdata (rx_rdata)
    );

    urb_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.start & tx_push),
        .i_waddr (tx_head_nx),
        .i_wdata (i_byte_in),
        .i_raddr (tx_tail_nx),
        .o_rdata (tx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_rx_en   <= 1'b1;
            r_tx_en   <= 1'b0;
            r_rx_pop  <= 1'b0;
            r_tx_pop  <= 1'b0;
        end else if (i_cmd.start) begin
            if (rx_push) r_rx_head <= rx_head_nx;
            if (rx_pop)  r_rx_tail <= rx_tail_nx;
            if (tx_push) r_tx_head <= tx_head_nx;
            if (tx_pop)  r_tx_tail <= tx_tail_nx;
            r_rx_en  <= n_rx_en;
            r_tx_en  <= n_tx_en;
            r_rx_pop <= rx_pop;
            r_tx_pop <= tx_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_read_byte <= '0;
            r_line_byte <= '0;
            r_line_send <= tx_pop;
            r_status    <= n_status;
        end else if (i_cmd.load) begin
            if (r_rx_pop) r_read_byte <= rx_rdata;
            if (r_tx_pop) r_line_byte <= tx_rdata;
        end
    end

    assign o_read_byte = r_read_byte;
    assign o_line_byte = r_line_byte;
    assign o_line_send = r_line_send;
    assign o_status    = r_status;
    assign o_rx_irq_on = r_rx_en;
    assign o_tx_irq_on = r_tx_en;

endmodule

`default_nettype wire

/* src/urb_ctrl.sv */
// Controller: sequences one event through decide, buffer read and result hand-off.
// Depends on urb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urb_ctrl import urb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output      logic o_in_ready,
    output      logic o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output      t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_sts.pop ? S_LOAD : S_OUT;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* src/uart_ring_buffer_pair_top.sv */
// Top level of the UART ring buffer pair: controller, datapath and checks.
// Depends on urb_pkg, urb_if, urb_ctrl, urb_datapath.
//
// Two ring buffers of DEPTH bytes (one slot always kept free) sit between a host
// and a serial line. Each input transfer is one event: host read, host write, line
// byte arrived, or line ready to send; each gives exactly one result transfer.
// One event is in flight at a time. An event that does not pop a buffer goes from
// accept straight to result shown; a pop adds a buffer read state between the two,
// because the buffer memory has a registered read port. The next event is taken
// the cycle after the result transfer. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module uart_ring_buffer_pair_top import urb_pkg::*; (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    urb_in_if.sink    i_in,
    urb_out_if.source o_out
);

    t_cmd cmd;
    t_sts sts;

    urb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    urb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_func      (i_in.func),
        .i_byte_in   (i_in.byte_in),
        .o_read_byte (o_out.read_byte),
        .o_line_byte (o_out.line_byte),
        .o_line_send (o_out.line_send),
        .o_status    (o_out.status),
        .o_rx_irq_on (o_out.rx_irq_on),
        .o_tx_irq_on (o_out.tx_irq_on)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("event accepted while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("ready did not drop after an input transfer");

    a_send_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.line_send) |-> (o_out.status == ST_OK))
        else $error("line byte sent with a non-ok status");

    a_overrun_disables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_OVERRUN) |-> !o_out.rx_irq_on)
        else $error("overrun left the receive interrupt enabled");

endmodule

`default_nettype wire
